[rtl/emd_pkg.sv]
// ----------------------------------------------------------------------------
// emd_pkg
// Shared types, field widths, codes and reset values of the energy and block
// demand meter.
// ----------------------------------------------------------------------------
package emd_pkg;

   localparam int NUM_TOTALS          = 4;
   localparam int TOTAL_IDX_WIDTH     = $clog2(NUM_TOTALS);
   localparam int COUNT_WIDTH         = 16;
   localparam int TOTAL_WIDTH_DEFAULT = 48;
   localparam int OUT_TOTAL_WIDTH     = 48;
   localparam int POWER_WIDTH         = 32;
   localparam int SUM_WIDTH           = 56;
   localparam int SCOUNT_WIDTH        = 24;
   localparam int PEAK_WIDTH          = 31;
   localparam int SPM_WIDTH           = 13;
   localparam int WM_WIDTH            = 11;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 13;
   localparam int KIND_WIDTH          = 2;
   localparam int DIV_STEP_WIDTH      = $clog2(SUM_WIDTH);

   localparam logic [SPM_WIDTH-1:0] SPM_RESET = SPM_WIDTH'(60);
   localparam logic [WM_WIDTH-1:0]  WM_RESET  = WM_WIDTH'(15);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLES_PER_MINUTE = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW_MINUTES     = CSR_INDEX_WIDTH'(1);

   localparam logic [KIND_WIDTH-1:0] KIND_POLL         = KIND_WIDTH'(0);
   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR_ENERGY = KIND_WIDTH'(1);
   localparam logic [KIND_WIDTH-1:0] KIND_CLEAR_DEMAND = KIND_WIDTH'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENERGY,
      ST_DEMAND,
      ST_CHECK,
      ST_DIVIDE,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic start;
      logic clear;
   } energy_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

[rtl/emd_energy_acc.sv]
// ----------------------------------------------------------------------------
// emd_energy_acc
// Four saturating energy totals updated one per cycle through a single
// shared adder.
// ----------------------------------------------------------------------------
module emd_energy_acc #(
   parameter int TOTAL_WIDTH = emd_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  emd_pkg::energy_cmd_type                                  cmd,
   input  logic [emd_pkg::NUM_TOTALS-1:0][emd_pkg::COUNT_WIDTH-1:0] counts,
   output logic [emd_pkg::NUM_TOTALS-1:0][TOTAL_WIDTH-1:0]          totals,
   output emd_pkg::unit_stat_type                                   stat
);

   localparam logic [emd_pkg::TOTAL_IDX_WIDTH-1:0] LAST_IDX =
      emd_pkg::TOTAL_IDX_WIDTH'(emd_pkg::NUM_TOTALS - 1);

   logic [emd_pkg::NUM_TOTALS-1:0][TOTAL_WIDTH-1:0] totals_ff;
   logic [emd_pkg::TOTAL_IDX_WIDTH-1:0]             idx_ff;
   logic                                            busy_ff;
   logic                                            done_ff;
   logic [TOTAL_WIDTH:0]                            sum_in;

   assign sum_in = {1'b0, totals_ff[idx_ff]} + (TOTAL_WIDTH + 1)'(counts[idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         totals_ff <= '0;
         idx_ff    <= '0;
         busy_ff   <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.clear) begin
            totals_ff <= '0;
         end else if (cmd.start) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (busy_ff) begin
            // saturate on carry out
            totals_ff[idx_ff] <= sum_in[TOTAL_WIDTH] ? '1 : sum_in[TOTAL_WIDTH-1:0];
            idx_ff            <= idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign totals    = totals_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/emd_divider.sv]
// ----------------------------------------------------------------------------
// emd_divider
// Restoring unsigned divider, one quotient bit per cycle through a shared
// subtractor.
// ----------------------------------------------------------------------------
module emd_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [emd_pkg::SUM_WIDTH-1:0]      dividend,
   input  logic [emd_pkg::SCOUNT_WIDTH-1:0]   divisor,
   output logic [emd_pkg::SUM_WIDTH-1:0]      quotient,
   output emd_pkg::unit_stat_type             stat
);

   localparam int DW = emd_pkg::SUM_WIDTH;
   localparam int RW = emd_pkg::SCOUNT_WIDTH;
   localparam logic [emd_pkg::DIV_STEP_WIDTH-1:0] LAST_STEP =
      emd_pkg::DIV_STEP_WIDTH'(DW - 1);

   logic [DW-1:0]                        quo_ff;
   logic [RW-1:0]                        rem_ff;
   logic [RW-1:0]                        divisor_ff;
   logic [emd_pkg::DIV_STEP_WIDTH-1:0]   step_ff;
   logic                                 busy_ff;
   logic                                 done_ff;
   logic [RW:0]                          shifted;
   logic [RW+1:0]                        diff;
   logic                                 fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor_ff};
   assign fits    = ~diff[RW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[RW-1:0] : shifted[RW-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[rtl/energy_and_block_demand_meter_core.sv]
// ----------------------------------------------------------------------------
// energy_and_block_demand_meter_core
// Energy totals, block interval demand and peak demand for a metering front
// end, run by a small sequencer over a shared adder and a serial divider.
//
//   channel   direction   handshake          contents
//   req_      in          req_valid/stall    kind, status flags, counts, power
//   rsp_      out         rsp_valid/stall    totals, demand, peak, closed flag
//   csr_      in          csr_write          samples per minute, window minutes
//
// a poll that closes a window is paced mostly by the 56-step restoring divider,
// one that does not by the four passes of the shared total adder (skipped
// without the energy pass); other requests go straight to the respond step.
// one request is in flight at a time; a finished result waits in the output
// register while the next request is accepted.
// reset is synchronous and restores control and state registers, no sweep; the
// request, divider and result data registers are not reset.
// a stalled result holds the sequencer in its last step until it is taken.
// ----------------------------------------------------------------------------
module energy_and_block_demand_meter_core #(
   parameter int TOTAL_WIDTH = emd_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [emd_pkg::KIND_WIDTH-1:0]            req_kind,
   input  logic                                      req_measure_ok,
   input  logic                                      req_energy_ok,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]           req_import_active_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]           req_export_active_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]           req_import_reactive_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]           req_export_reactive_count,
   input  logic signed [emd_pkg::POWER_WIDTH-1:0]    req_total_power,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]       rsp_import_active_total,
   output logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]       rsp_export_active_total,
   output logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]       rsp_import_reactive_total,
   output logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]       rsp_export_reactive_total,
   output logic signed [emd_pkg::POWER_WIDTH-1:0]    rsp_demand_now,
   output logic [emd_pkg::PEAK_WIDTH-1:0]            rsp_demand_peak,
   output logic                                      rsp_window_closed,

   input  logic                                      csr_write,
   input  logic [emd_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [emd_pkg::CSR_DATA_WIDTH-1:0]        csr_wdata
);

   localparam int OTW = emd_pkg::OUT_TOTAL_WIDTH;
   localparam int EXT_WIDTH = (TOTAL_WIDTH > OTW) ? TOTAL_WIDTH : OTW;
   localparam int SW  = emd_pkg::SUM_WIDTH;
   localparam int CW  = emd_pkg::SCOUNT_WIDTH;
   localparam int PW  = emd_pkg::POWER_WIDTH;
   localparam int MW  = emd_pkg::PEAK_WIDTH;

   emd_pkg::state_type state_ff;
   emd_pkg::state_type state_in;

   logic [emd_pkg::SPM_WIDTH-1:0]   spm_ff;
   logic [emd_pkg::WM_WIDTH-1:0]    wm_ff;
   logic [CW-1:0]                   win_ff;
   logic [emd_pkg::WM_WIDTH-1:0]    wm_eff;
   logic [CW-1:0]                   win_prod;

   logic signed [PW-1:0]            power_ff;
   logic [emd_pkg::NUM_TOTALS-1:0][emd_pkg::COUNT_WIDTH-1:0] counts_ff;

   logic signed [SW-1:0]            sum_ff;
   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_inc;
   logic signed [PW-1:0]            demand_ff;
   logic [MW-1:0]                   peak_ff;
   logic                            closed_ff;

   logic                            rsp_valid_ff;
   logic [OTW-1:0]                  rsp_ia_ff;
   logic [OTW-1:0]                  rsp_ea_ff;
   logic [OTW-1:0]                  rsp_ir_ff;
   logic [OTW-1:0]                  rsp_er_ff;
   logic signed [PW-1:0]            rsp_demand_ff;
   logic [MW-1:0]                   rsp_peak_ff;
   logic                            rsp_closed_ff;

   logic                            accept;
   logic                            is_poll_ok;
   logic                            window_full;
   logic                            div_start;
   logic                            load_rsp;
   emd_pkg::energy_cmd_type         energy_cmd;
   emd_pkg::unit_stat_type          energy_stat;
   emd_pkg::unit_stat_type          div_stat;

   logic [emd_pkg::NUM_TOTALS-1:0][TOTAL_WIDTH-1:0] totals;
   logic [emd_pkg::NUM_TOTALS-1:0][EXT_WIDTH-1:0]   totals_ext;

   logic [SW-1:0]                   sum_mag;
   logic [SW-1:0]                   div_quo;
   logic [PW-1:0]                   quo_low;
   logic [PW-1:0]                   quo_signed;

   // configuration and window length
   assign wm_eff   = (wm_ff == '0) ? emd_pkg::WM_WIDTH'(1) : wm_ff;
   assign win_prod = CW'(spm_ff) * CW'(wm_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff <= emd_pkg::SPM_RESET;
         wm_ff  <= emd_pkg::WM_RESET;
         win_ff <= CW'(1);
      end else begin
         win_ff <= (win_prod == '0) ? CW'(1) : win_prod;
         if (csr_write && (csr_index == emd_pkg::CSR_SAMPLES_PER_MINUTE)) begin
            spm_ff <= csr_wdata[emd_pkg::SPM_WIDTH-1:0];
         end
         if (csr_write && (csr_index == emd_pkg::CSR_WINDOW_MINUTES)) begin
            wm_ff <= csr_wdata[emd_pkg::WM_WIDTH-1:0];
         end
      end
   end

   // request capture
   assign req_stall  = (state_ff != emd_pkg::ST_IDLE);
   assign accept     = req_valid && !req_stall;
   assign is_poll_ok = (req_kind == emd_pkg::KIND_POLL) && req_measure_ok;

   always_ff @(posedge clock) begin
      if (accept) begin
         power_ff      <= req_total_power;
         counts_ff[0]  <= req_import_active_count;
         counts_ff[1]  <= req_export_active_count;
         counts_ff[2]  <= req_import_reactive_count;
         counts_ff[3]  <= req_export_reactive_count;
      end
   end

   // sequencer
   assign window_full = (count_ff >= win_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         emd_pkg::ST_IDLE: begin
            if (accept) begin
               if (is_poll_ok) begin
                  state_in = req_energy_ok ? emd_pkg::ST_ENERGY : emd_pkg::ST_DEMAND;
               end else begin
                  state_in = emd_pkg::ST_RESPOND;
               end
            end
         end
         emd_pkg::ST_ENERGY: begin
            if (energy_stat.done) begin
               state_in = emd_pkg::ST_DEMAND;
            end
         end
         emd_pkg::ST_DEMAND: begin
            state_in = emd_pkg::ST_CHECK;
         end
         emd_pkg::ST_CHECK: begin
            state_in = window_full ? emd_pkg::ST_DIVIDE : emd_pkg::ST_RESPOND;
         end
         emd_pkg::ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = emd_pkg::ST_RESPOND;
            end
         end
         emd_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = emd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = emd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      energy_cmd.start = accept && is_poll_ok && req_energy_ok;
      energy_cmd.clear = accept && (req_kind == emd_pkg::KIND_CLEAR_ENERGY);
      div_start        = (state_ff == emd_pkg::ST_CHECK) && window_full;
      load_rsp         = (state_ff == emd_pkg::ST_RESPOND) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // energy totals
   emd_energy_acc #(
      .TOTAL_WIDTH (TOTAL_WIDTH)
   ) u_energy (
      .clock  (clock),
      .reset  (reset),
      .cmd    (energy_cmd),
      .counts (counts_ff),
      .totals (totals),
      .stat   (energy_stat)
   );

   // demand divider
   assign sum_mag = sum_ff[SW-1] ? (~SW'(sum_ff) + SW'(1)) : SW'(sum_ff);

   emd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign quo_low    = div_quo[PW-1:0];
   assign quo_signed = sum_ff[SW-1] ? (~quo_low + PW'(1)) : quo_low;
   assign count_inc  = count_ff + CW'(1);

   // demand state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         demand_ff <= '0;
         peak_ff   <= '0;
         closed_ff <= 1'b0;
      end else begin
         if (csr_write && (csr_index == emd_pkg::CSR_WINDOW_MINUTES)) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end
         if (accept) begin
            closed_ff <= 1'b0;
            if (req_kind == emd_pkg::KIND_CLEAR_DEMAND) begin
               sum_ff    <= '0;
               count_ff  <= '0;
               demand_ff <= '0;
               peak_ff   <= '0;
            end
         end
         if (state_ff == emd_pkg::ST_DEMAND) begin
            sum_ff   <= sum_ff + SW'(power_ff);
            count_ff <= (count_inc == '0) ? CW'(1) : count_inc;
         end
         if ((state_ff == emd_pkg::ST_DIVIDE) && div_stat.done) begin
            demand_ff <= signed'(quo_signed);
            if (!quo_signed[PW-1] && (quo_signed != '0) && (quo_signed[MW-1:0] > peak_ff)) begin
               peak_ff <= quo_signed[MW-1:0];
            end
            sum_ff    <= '0;
            count_ff  <= '0;
            closed_ff <= 1'b1;
         end
      end
   end

   // result register
   always_comb begin
      for (int i = 0; i < emd_pkg::NUM_TOTALS; i++) begin
         totals_ext[i] = EXT_WIDTH'(totals[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ia_ff     <= totals_ext[0][OTW-1:0];
         rsp_ea_ff     <= totals_ext[1][OTW-1:0];
         rsp_ir_ff     <= totals_ext[2][OTW-1:0];
         rsp_er_ff     <= totals_ext[3][OTW-1:0];
         rsp_demand_ff <= demand_ff;
         rsp_peak_ff   <= peak_ff;
         rsp_closed_ff <= closed_ff;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_import_active_total   = rsp_ia_ff;
   assign rsp_export_active_total   = rsp_ea_ff;
   assign rsp_import_reactive_total = rsp_ir_ff;
   assign rsp_export_reactive_total = rsp_er_ff;
   assign rsp_demand_now            = rsp_demand_ff;
   assign rsp_demand_peak           = rsp_peak_ff;
   assign rsp_window_closed         = rsp_closed_ff;

   // checks
   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == emd_pkg::ST_RESPOND))
      else $error("result raised outside the respond step");

   a_peak_holds_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != emd_pkg::ST_IDLE) |=> (peak_ff >= $past(peak_ff)))
      else $error("peak demand fell while a request was in progress");

   a_energy_busy_state: assert property (@(posedge clock) disable iff (reset)
      energy_stat.busy |-> (state_ff == emd_pkg::ST_ENERGY))
      else $error("energy adder running outside its step");

   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == emd_pkg::ST_DIVIDE))
      else $error("divider running outside its step");

endmodule

[bench/meter_reading_checker.sv]
// ----------------------------------------------------------------------------
// meter_reading_checker
// Watches the request, result and csr ports of the demand meter core, keeps
// its own copy of the energy totals, the block demand window and the peak,
// predicts the reading each accepted request must produce and compares every
// accepted result field by field against the oldest reading still due.
// ----------------------------------------------------------------------------
module meter_reading_checker #(
   parameter int TOTAL_WIDTH = emd_pkg::TOTAL_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [emd_pkg::KIND_WIDTH-1:0]         req_kind,
   input  logic                                   req_measure_ok,
   input  logic                                   req_energy_ok,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]        req_import_active_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]        req_export_active_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]        req_import_reactive_count,
   input  logic [emd_pkg::COUNT_WIDTH-1:0]        req_export_reactive_count,
   input  logic signed [emd_pkg::POWER_WIDTH-1:0] req_total_power,

   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    rsp_import_active_total,
   input  logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    rsp_export_active_total,
   input  logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    rsp_import_reactive_total,
   input  logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    rsp_export_reactive_total,
   input  logic signed [emd_pkg::POWER_WIDTH-1:0] rsp_demand_now,
   input  logic [emd_pkg::PEAK_WIDTH-1:0]         rsp_demand_peak,
   input  logic                                   rsp_window_closed,

   input  logic                                   csr_write,
   input  logic [emd_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [emd_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,

   output int                                     mismatch_count,
   output int                                     readings_due,
   output int                                     windows_closed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    import_active;
      logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    export_active;
      logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    import_reactive;
      logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]    export_reactive;
      logic signed [emd_pkg::POWER_WIDTH-1:0] demand_now;
      logic [emd_pkg::PEAK_WIDTH-1:0]         demand_peak;
      logic                                   window_closed;
   } meter_reading_type;

   meter_reading_type                due_readings[$];

   logic [emd_pkg::SPM_WIDTH-1:0]    samples_per_min;
   logic [emd_pkg::WM_WIDTH-1:0]     window_min;
   logic [63:0]                      energy_total [emd_pkg::NUM_TOTALS];
   longint                           demand_acc;
   logic [emd_pkg::SCOUNT_WIDTH-1:0] samples_in_window;
   logic signed [31:0]               demand_avg;
   logic [emd_pkg::PEAK_WIDTH-1:0]   demand_top;

   initial begin
      mismatch_count = 0;
      windows_closed = 0;
   end

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: %s mismatch, got %h expected %h", $time, field, got, want);
   endtask

   function automatic logic [63:0] saturating_sum(input logic [63:0] total,
                                                  input logic [63:0] add);
      logic [63:0] ceiling;
      ceiling = {64{1'b1}} >> (64 - TOTAL_WIDTH);
      if (total > ceiling)
         total = ceiling;
      return (add > ceiling - total) ? ceiling : total + add;
   endfunction

   function automatic meter_reading_type predict_reading(
      input logic [emd_pkg::KIND_WIDTH-1:0]         kind,
      input logic                                   measure_ok,
      input logic                                   energy_ok,
      input logic [3:0][emd_pkg::COUNT_WIDTH-1:0]   counts,
      input logic signed [emd_pkg::POWER_WIDTH-1:0] power
   );
      meter_reading_type r;
      logic [63:0]       span;
      longint            quotient;
      int                i;
      r.window_closed = 1'b0;
      case (kind)
         emd_pkg::KIND_POLL: begin
            if (measure_ok) begin
               if (energy_ok)
                  for (i = 0; i < emd_pkg::NUM_TOTALS; i++)
                     energy_total[i] = saturating_sum(energy_total[i], 64'(counts[i]));
               span = 64'(samples_per_min) * ((window_min == 0) ? 64'd1 : 64'(window_min));
               if (span == 0)
                  span = 64'd1;
               demand_acc = demand_acc + longint'(power);
               samples_in_window = samples_in_window + 1'b1;
               if (samples_in_window == 0)
                  samples_in_window = 1;
               if (64'(samples_in_window) >= span) begin
                  quotient = demand_acc / longint'(64'(samples_in_window));
                  demand_avg = quotient[31:0];
                  if (demand_avg > 0 && demand_avg[emd_pkg::PEAK_WIDTH-1:0] > demand_top)
                     demand_top = demand_avg[emd_pkg::PEAK_WIDTH-1:0];
                  demand_acc = 0;
                  samples_in_window = 0;
                  r.window_closed = 1'b1;
               end
            end
         end
         emd_pkg::KIND_CLEAR_ENERGY: begin
            for (i = 0; i < emd_pkg::NUM_TOTALS; i++)
               energy_total[i] = 64'd0;
         end
         emd_pkg::KIND_CLEAR_DEMAND: begin
            demand_acc = 0;
            samples_in_window = 0;
            demand_avg = 0;
            demand_top = 0;
         end
         default: ;
      endcase
      r.import_active   = energy_total[0][emd_pkg::OUT_TOTAL_WIDTH-1:0];
      r.export_active   = energy_total[1][emd_pkg::OUT_TOTAL_WIDTH-1:0];
      r.import_reactive = energy_total[2][emd_pkg::OUT_TOTAL_WIDTH-1:0];
      r.export_reactive = energy_total[3][emd_pkg::OUT_TOTAL_WIDTH-1:0];
      r.demand_now      = demand_avg;
      r.demand_peak     = demand_top;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      meter_reading_type want;
      int                i;
      if (reset) begin
         samples_per_min = emd_pkg::SPM_RESET;
         window_min = emd_pkg::WM_RESET;
         for (i = 0; i < emd_pkg::NUM_TOTALS; i++)
            energy_total[i] = 64'd0;
         demand_acc = 0;
         samples_in_window = 0;
         demand_avg = 0;
         demand_top = 0;
         due_readings.delete();
      end else begin
         // the result leaving now belongs to an older request than one entering now
         if (rsp_valid && !rsp_stall) begin
            if (due_readings.size() == 0) begin
               report_mismatch("result with no request due", 64'(rsp_window_closed), 64'd0);
            end else begin
               want = due_readings.pop_front();
               if (want.window_closed)
                  windows_closed++;
               if (rsp_import_active_total !== want.import_active)
                  report_mismatch("import_active_total", rsp_import_active_total,
                                  want.import_active);
               if (rsp_export_active_total !== want.export_active)
                  report_mismatch("export_active_total", rsp_export_active_total,
                                  want.export_active);
               if (rsp_import_reactive_total !== want.import_reactive)
                  report_mismatch("import_reactive_total", rsp_import_reactive_total,
                                  want.import_reactive);
               if (rsp_export_reactive_total !== want.export_reactive)
                  report_mismatch("export_reactive_total", rsp_export_reactive_total,
                                  want.export_reactive);
               if (rsp_demand_now !== want.demand_now)
                  report_mismatch("demand_now", 64'(rsp_demand_now), 64'(want.demand_now));
               if (rsp_demand_peak !== want.demand_peak)
                  report_mismatch("demand_peak", 64'(rsp_demand_peak), 64'(want.demand_peak));
               if (rsp_window_closed !== want.window_closed)
                  report_mismatch("window_closed", 64'(rsp_window_closed),
                                  64'(want.window_closed));
            end
         end
         if (csr_write) begin
            case (csr_index)
               emd_pkg::CSR_SAMPLES_PER_MINUTE:
                  samples_per_min = csr_wdata[emd_pkg::SPM_WIDTH-1:0];
               emd_pkg::CSR_WINDOW_MINUTES: begin
                  window_min = csr_wdata[emd_pkg::WM_WIDTH-1:0];
                  demand_acc = 0;
                  samples_in_window = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            due_readings.push_back(predict_reading(req_kind, req_measure_ok, req_energy_ok,
               {req_export_reactive_count, req_import_reactive_count,
                req_export_active_count, req_import_active_count},
               req_total_power));
      end
      readings_due <= due_readings.size();
   end

endmodule

[bench/tb_energy_and_block_demand_meter_core.sv]
// ----------------------------------------------------------------------------
// tb_energy_and_block_demand_meter_core
// Drives poll, clear and unused requests and csr writes into the demand meter
// core: a directed opening over the corner cases, then three random phases
// with sender and receiver idling in turn. The checker beside the block does
// the prediction; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_energy_and_block_demand_meter_core;
   timeunit 1ns;
   timeprecision 1ps;

   // total width narrower than the result fields
   localparam int TOTAL_BITS       = 32;
   localparam int QUIET_LIMIT      = 4000;
   localparam int BLOCK_ITEMS      = 95;
   localparam int BLOCKS_PER_PHASE = 7;
   localparam int DRAIN_CYCLES     = 80;

   localparam logic [emd_pkg::KIND_WIDTH-1:0]      KIND_RESERVED =
      emd_pkg::KIND_WIDTH'(3);
   localparam logic [emd_pkg::CSR_INDEX_WIDTH-1:0] CSR_RESERVED  =
      emd_pkg::CSR_INDEX_WIDTH'(3);

   typedef struct packed {
      logic [emd_pkg::KIND_WIDTH-1:0]         kind;
      logic                                   measure_ok;
      logic                                   energy_ok;
      logic [3:0][emd_pkg::COUNT_WIDTH-1:0]   counts;
      logic [emd_pkg::POWER_WIDTH-1:0]        power;
   } meter_request_type;

   logic                                       clock = 1'b0;
   logic                                       reset = 1'b1;

   logic                                       req_valid = 1'b0;
   logic                                       req_stall;
   logic [emd_pkg::KIND_WIDTH-1:0]             req_kind = '0;
   logic                                       req_measure_ok = 1'b0;
   logic                                       req_energy_ok = 1'b0;
   logic [emd_pkg::COUNT_WIDTH-1:0]            req_import_active_count = '0;
   logic [emd_pkg::COUNT_WIDTH-1:0]            req_export_active_count = '0;
   logic [emd_pkg::COUNT_WIDTH-1:0]            req_import_reactive_count = '0;
   logic [emd_pkg::COUNT_WIDTH-1:0]            req_export_reactive_count = '0;
   logic signed [emd_pkg::POWER_WIDTH-1:0]     req_total_power = '0;

   logic                                       rsp_valid;
   logic                                       rsp_stall = 1'b0;
   logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]        rsp_import_active_total;
   logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]        rsp_export_active_total;
   logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]        rsp_import_reactive_total;
   logic [emd_pkg::OUT_TOTAL_WIDTH-1:0]        rsp_export_reactive_total;
   logic signed [emd_pkg::POWER_WIDTH-1:0]     rsp_demand_now;
   logic [emd_pkg::PEAK_WIDTH-1:0]             rsp_demand_peak;
   logic                                       rsp_window_closed;

   logic                                       csr_write = 1'b0;
   logic [emd_pkg::CSR_INDEX_WIDTH-1:0]        csr_index = '0;
   logic [emd_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata = '0;

   int                                         mismatch_count;
   int                                         readings_due;
   int                                         windows_closed;

   int                                         gap_pct = 0;
   int                                         hold_pct = 0;
   int                                         quiet_cycles = 0;
   int                                         sent = 0;
   int                                         register_writes = 0;
   bit                                         offering = 1'b0;

   energy_and_block_demand_meter_core #(.TOTAL_WIDTH(TOTAL_BITS)) DUT (.*);

   meter_reading_checker #(.TOTAL_WIDTH(TOTAL_BITS)) reading_check (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99, 0) < hold_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_energy_and_block_demand_meter_core: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic meter_request_type request_of(
      input logic [emd_pkg::KIND_WIDTH-1:0]  kind,
      input logic                            measure_ok,
      input logic                            energy_ok,
      input logic [emd_pkg::COUNT_WIDTH-1:0] count,
      input logic [emd_pkg::POWER_WIDTH-1:0] power
   );
      meter_request_type r;
      r.kind = kind;
      r.measure_ok = measure_ok;
      r.energy_ok = energy_ok;
      r.counts = {4{count}};
      r.power = power;
      return r;
   endfunction

   function automatic meter_request_type random_request();
      meter_request_type r;
      int                pick;
      int                i;
      pick = $urandom_range(99, 0);
      r.kind = (pick < 82) ? emd_pkg::KIND_POLL : (pick < 88) ? emd_pkg::KIND_CLEAR_ENERGY :
               (pick < 94) ? emd_pkg::KIND_CLEAR_DEMAND : KIND_RESERVED;
      r.measure_ok = ($urandom_range(9, 0) != 0);
      r.energy_ok = ($urandom_range(6, 0) != 0);
      for (i = 0; i < 4; i++) begin
         case ($urandom_range(3, 0))
            0: r.counts[i] = '0;
            1: r.counts[i] = '1;
            default: r.counts[i] = emd_pkg::COUNT_WIDTH'($urandom);
         endcase
      end
      case ($urandom_range(5, 0))
         0: r.power = 32'h7FFF_FFFF;
         1: r.power = 32'h8000_0000;
         2: r.power = 32'($urandom_range(2000, 0)) - 32'd1000;
         default: r.power = $urandom;
      endcase
      return r;
   endfunction

   function automatic logic [emd_pkg::CSR_DATA_WIDTH-1:0] pick_samples_per_minute();
      case ($urandom_range(7, 0))
         0: return emd_pkg::CSR_DATA_WIDTH'(6000);
         1: return emd_pkg::CSR_DATA_WIDTH'($urandom_range(8191, 0));
         default: return emd_pkg::CSR_DATA_WIDTH'($urandom_range(6, 0));
      endcase
   endfunction

   // upper data bits beyond the register width are random
   function automatic logic [emd_pkg::CSR_DATA_WIDTH-1:0] pick_window_minutes();
      logic [emd_pkg::WM_WIDTH-1:0] minutes;
      case ($urandom_range(7, 0))
         0: minutes = emd_pkg::WM_WIDTH'(1440);
         1: minutes = emd_pkg::WM_WIDTH'($urandom_range(2047, 0));
         default: minutes = emd_pkg::WM_WIDTH'($urandom_range(3, 0));
      endcase
      return {2'($urandom), minutes};
   endfunction

   task automatic send_request(input meter_request_type r);
      while ($urandom_range(99, 0) < gap_pct) begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         @(posedge clock);
      end
      req_valid <= 1'b1;
      offering = 1'b1;
      req_kind <= r.kind;
      req_measure_ok <= r.measure_ok;
      req_energy_ok <= r.energy_ok;
      req_import_active_count <= r.counts[0];
      req_export_active_count <= r.counts[1];
      req_import_reactive_count <= r.counts[2];
      req_export_reactive_count <= r.counts[3];
      req_total_power <= r.power;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic settle();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (readings_due != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [emd_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [emd_pkg::CSR_DATA_WIDTH-1:0] value);
      settle();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      register_writes++;
   endtask

   initial begin : stimulus
      int phase;
      int block;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corners under the reset window
      send_request(request_of(emd_pkg::KIND_POLL, 1'b0, 1'b1, 16'hFFFF, 32'h7FFF_FFFF));
      send_request(request_of(KIND_RESERVED, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b0, 16'hFFFF, 32'h8000_0000));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'hFFFF, 32'h7FFF_FFFF));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'h0000, 32'h0000_0000));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'h1234, -32'sd1234));
      send_request(request_of(emd_pkg::KIND_CLEAR_ENERGY, 1'b0, 1'b0, 16'hFFFF, 32'd7));

      // one-sample windows: negative demand, both power extremes, demand clear
      write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, 13'd1);
      write_register(emd_pkg::CSR_WINDOW_MINUTES, 13'd1);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b0, 16'd0, -32'sd5));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd1, 32'h7FFF_FFFF));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd2, 32'h8000_0000));
      send_request(request_of(emd_pkg::KIND_CLEAR_DEMAND, 1'b0, 1'b1, 16'hFFFF, 32'd0));
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd3, 32'd9));

      // zero window
      write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, 13'd0);
      write_register(emd_pkg::CSR_WINDOW_MINUTES, 13'd0);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd4, 32'd100));

      // register width extremes
      write_register(emd_pkg::CSR_WINDOW_MINUTES, 13'h1FFF);
      write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, 13'h1FFF);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'hFFFF, 32'h7FFF_FFFF));

      // window shortened under five gathered samples, closes with truncation toward zero
      write_register(emd_pkg::CSR_WINDOW_MINUTES, 13'd1);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd5, -32'sd5));
      repeat (4) send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b0, 16'd6, -32'sd1));
      write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, 13'd3);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd6, -32'sd2));

      write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, 13'd6000);
      write_register(emd_pkg::CSR_WINDOW_MINUTES, 13'd1440);
      send_request(request_of(emd_pkg::KIND_POLL, 1'b1, 1'b1, 16'd7, 32'd55));
      write_register(CSR_RESERVED, 13'h1FFF);
      send_request(request_of(emd_pkg::KIND_CLEAR_DEMAND, 1'b1, 1'b0, 16'h00FF, 32'd1));
      send_request(request_of(emd_pkg::KIND_CLEAR_ENERGY, 1'b1, 1'b1, 16'hFF00, 32'd2));

      // random phases: receiver idles most, then sender idles most, then neither
      for (phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 21 : (phase == 1) ? 48 : 0;
         hold_pct <= (phase == 0) ? 48 : (phase == 1) ? 21 : 0;
         for (block = 0; block < BLOCKS_PER_PHASE; block++) begin
            write_register(emd_pkg::CSR_SAMPLES_PER_MINUTE, pick_samples_per_minute());
            if ($urandom_range(2, 0) != 0)
               write_register(emd_pkg::CSR_WINDOW_MINUTES, pick_window_minutes());
            repeat (BLOCK_ITEMS) send_request(random_request());
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests over directed corners and three idling phases",
               sent);
      $display("%0d csr writes, %0d demand windows closed, %0d field mismatches",
               register_writes, windows_closed, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_energy_and_block_demand_meter_core: clean");
      else
         $display("tb_energy_and_block_demand_meter_core: errors");
      $finish;
   end

endmodule

[files.f]
rtl/emd_pkg.sv
rtl/emd_energy_acc.sv
rtl/emd_divider.sv
rtl/energy_and_block_demand_meter_core.sv
bench/meter_reading_checker.sv
bench/tb_energy_and_block_demand_meter_core.sv
